// File: sv/fpa_pkg.sv
// Shared types, opcodes and sizing constants of the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DATA_W        = 32;
    // Quotient bits resolved by each divider stage.
    localparam int DIV_BITS      = 4;
    localparam int DIV_STAGES    = DATA_W / DIV_BITS;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_LT,
        OP_GT,
        OP_LE,
        OP_GE,
        OP_EQ,
        OP_NE,
        OP_MIN,
        OP_MAX,
        OP_INC,
        OP_DEC,
        OP_TOINT,
        OP_FROMINT
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       opcode;
        logic signed [DATA_W-1:0]  operand_a;
        logic signed [DATA_W-1:0]  operand_b;
    } fpa_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  result;
        logic                      flag;
        status_t                   status;
    } fpa_rsp_t;

    // One item as it travels down the divider stages.
    typedef struct packed {
        logic                      valid;
        logic                      is_div;
        logic                      neg;
        logic                      ovf;
        logic                      dzero;
        logic [DATA_W-1:0]         rem;
        logic [DATA_W-1:0]         quo;
        logic [DATA_W-1:0]         den;
        logic signed [DATA_W-1:0]  result;
        logic                      flag;
        status_t                   status;
    } fpa_stage_t;

endpackage

// File: sv/fpa_div_stage.sv
// One registered stage of the restoring divider, resolving DIV_BITS quotient bits.
module fpa_div_stage
    import fpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  fpa_stage_t  d,
    output fpa_stage_t  q
);

    fpa_stage_t stage_next;
    fpa_stage_t stage_reg;
    logic       valid_reg;

    // Each step shifts one dividend bit into the remainder and keeps the
    // difference when the divisor fits; the quotient bit enters at the bottom.
    always_comb
    begin
        logic [DATA_W:0] r;
        logic            qbit;
        stage_next = d;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r    = {stage_next.rem, stage_next.quo[DATA_W-1]};
            qbit = (r >= {1'b0, stage_next.den});
            if (qbit)
            begin
                r = r - {1'b0, stage_next.den};
            end
            stage_next.rem = r[DATA_W-1:0];
            stage_next.quo = {stage_next.quo[DATA_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        q       = stage_reg;
        q.valid = valid_reg;
    end

endmodule

// File: sv/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
// Every opcode alike passes through stage 0, the divider stages and the output register.
// Throughput is one item per cycle while rsp_stall does not hold the pipeline; the eight divider stages set the depth.
// All stages advance together and hold while a finished item waits on rsp_stall.
// rst_n clears every valid bit asynchronously; the datapath registers are not reset.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  fpa_req_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output fpa_rsp_t  rsp
);

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // Clamp a wide signed value into the 32-bit word.
    function automatic logic signed [DATA_W-1:0] clamp(input logic signed [63:0] v);
        if (v > SAT_HI)
        begin
            return SAT_HI[DATA_W-1:0];
        end
        if (v < SAT_LO)
        begin
            return SAT_LO[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic clipped(input logic signed [63:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    logic      rsp_valid_reg;
    fpa_rsp_t  rsp_reg;
    fpa_rsp_t  rsp_next;

    // The whole pipeline moves unless the output register holds an item that
    // the consumer is not taking.
    logic adv;
    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    // ---------------------------------------------------------------------
    // Stage 0: simple operations finish here, the product is formed, and the
    // divider operands are prepared as magnitudes.
    // ---------------------------------------------------------------------
    fpa_stage_t               s0_next;
    fpa_stage_t               s0_reg;
    logic                     s0_valid_reg;
    logic signed [63:0]       prod_next;
    logic signed [63:0]       prod_reg;
    logic                     mul_reg;

    always_comb
    begin
        logic signed [63:0]  a64;
        logic signed [63:0]  b64;
        logic signed [63:0]  v;
        logic [DATA_W-1:0]   mag_a;
        logic [DATA_W-1:0]   mag_b;
        logic [63:0]         num;
        a64   = 64'(req.operand_a);
        b64   = 64'(req.operand_b);
        mag_a = req.operand_a[DATA_W-1] ? DATA_W'(-req.operand_a) : req.operand_a;
        mag_b = req.operand_b[DATA_W-1] ? DATA_W'(-req.operand_b) : req.operand_b;
        num   = {32'd0, mag_a} << FRAC_BITS;
        v     = 64'sd0;

        s0_next        = '0;
        s0_next.valid  = req_valid;
        s0_next.is_div = (req.opcode == OP_DIV);
        s0_next.neg    = req.operand_a[DATA_W-1] ^ req.operand_b[DATA_W-1];
        s0_next.rem    = num[63:32];
        s0_next.quo    = num[31:0];
        s0_next.den    = mag_b;
        // A high half that already reaches the divisor means a quotient of at
        // least 2^32, which saturates whatever the sign.
        s0_next.ovf    = (num[63:32] >= mag_b);
        s0_next.dzero  = (req.operand_b == '0);
        s0_next.status = ST_OK;
        prod_next      = a64 * b64;

        case (req.opcode)
            OP_ADD:     v = a64 + b64;
            OP_SUB:     v = a64 - b64;
            OP_INC:     v = a64 + 64'sd1;
            OP_DEC:     v = a64 - 64'sd1;
            OP_FROMINT: v = a64 <<< FRAC_BITS;
            default:    v = 64'sd0;
        endcase

        case (req.opcode)
            OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_FROMINT:
            begin
                s0_next.result = clamp(v);
                s0_next.status = clipped(v) ? ST_SAT : ST_OK;
            end
            OP_LT: s0_next.flag = (req.operand_a <  req.operand_b);
            OP_GT: s0_next.flag = (req.operand_a >  req.operand_b);
            OP_LE: s0_next.flag = (req.operand_a <= req.operand_b);
            OP_GE: s0_next.flag = (req.operand_a >= req.operand_b);
            OP_EQ: s0_next.flag = (req.operand_a == req.operand_b);
            OP_NE: s0_next.flag = (req.operand_a != req.operand_b);
            OP_MIN:
                s0_next.result = (req.operand_a < req.operand_b) ? req.operand_a
                                                                 : req.operand_b;
            OP_MAX:
                s0_next.result = (req.operand_a > req.operand_b) ? req.operand_a
                                                                 : req.operand_b;
            OP_TOINT: s0_next.result = req.operand_a >>> FRAC_BITS;
            default:  s0_next.result = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg   <= s0_next;
            prod_reg <= prod_next;
            mul_reg  <= (req.opcode == OP_MUL);
        end
    end

    // ---------------------------------------------------------------------
    // The product is rounded half away from zero on its way into the first
    // divider stage, which carries it along untouched.
    // ---------------------------------------------------------------------
    fpa_stage_t div_in;
    fpa_stage_t pipe_d [DIV_STAGES];
    fpa_stage_t pipe_q [DIV_STAGES];

    always_comb
    begin
        logic [63:0]        pm;
        logic [63:0]        qm;
        logic signed [63:0] qs;
        pm = prod_reg[63] ? 64'(-prod_reg) : prod_reg;
        qm = (pm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        qs = prod_reg[63] ? -$signed(qm) : $signed(qm);
        div_in       = s0_reg;
        div_in.valid = s0_valid_reg;
        if (mul_reg)
        begin
            div_in.result = clamp(qs);
            div_in.status = clipped(qs) ? ST_SAT : ST_OK;
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        if (g > 0)
        begin : g_link
            assign pipe_d[g] = pipe_q[g-1];
        end
        else
        begin : g_head
            assign pipe_d[g] = div_in;
        end
        fpa_div_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     (pipe_d[g]),
            .q     (pipe_q[g])
        );
    end

    // ---------------------------------------------------------------------
    // Output stage: the quotient is rounded from the final remainder, signed
    // and clamped; divide by zero overrides everything.
    // ---------------------------------------------------------------------
    fpa_stage_t last;
    assign last = pipe_q[DIV_STAGES-1];

    always_comb
    begin
        logic              up;
        logic [DATA_W:0]   qv;
        logic              sat;
        up  = ({last.rem, 1'b0} >= {1'b0, last.den});
        qv  = {1'b0, last.quo} + (DATA_W+1)'(up);
        sat = last.ovf || (last.neg ? (qv > (33'd1 << (DATA_W-1)))
                                    : (qv > ((33'd1 << (DATA_W-1)) - 33'd1)));
        rsp_next.result = last.result;
        rsp_next.flag   = last.flag;
        rsp_next.status = last.status;
        if (last.is_div)
        begin
            if (last.dzero)
            begin
                rsp_next.result = '0;
                rsp_next.status = ST_DIVZ;
            end
            else if (sat)
            begin
                rsp_next.result = last.neg ? SAT_LO[DATA_W-1:0] : SAT_HI[DATA_W-1:0];
                rsp_next.status = ST_SAT;
            end
            else
            begin
                rsp_next.result = last.neg ? DATA_W'(-qv[DATA_W-1:0]) : qv[DATA_W-1:0];
                rsp_next.status = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_DIVZ |-> rsp.result == '0)
        else $error("divide by zero item carries a nonzero result");

    a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.flag |-> rsp.result == '0 && rsp.status == ST_OK)
        else $error("comparison item carries a result or status");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_SAT |->
            rsp.result == SAT_HI[DATA_W-1:0] || rsp.result == SAT_LO[DATA_W-1:0])
        else $error("saturated item is not at a bound");
`endif

endmodule
